[hdl/crc_frm_pkg.sv]
// ----------------------------------------------------------------------------
// CRC frame receiver package
// Shared types, constants and the CRC-16 byte update for the length-prefixed
// frame receiver.
// ----------------------------------------------------------------------------
package crc_frm_pkg;

  // CRC-16 with polynomial 0x1021, MSB first, no final xor.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame layout limits and byte positions.
  localparam logic [7:0] MIN_FRAME  = 8'd4;
  localparam logic [7:0] MIN_STATUS = 8'd19;
  localparam int         POS_FIRST  = 2;   // first byte of the X position word
  localparam int         FLAG_FIRST = 14;  // byte that carries the X switch flag
  localparam int         NUM_AXES   = 3;

  // Configuration register indexes.
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_STATUS_TYPE  = 2'd0;
  localparam logic [1:0] CFG_ACK_TYPE     = 2'd1;
  localparam logic [1:0] CFG_ERROR_TYPE   = 2'd2;

  // Output data width: 115 payload bits padded to whole bytes.
  localparam int OUT_DATA_W = 120;

  typedef enum logic [2:0] {
    KIND_STATUS    = 3'd0,
    KIND_ACK       = 3'd1,
    KIND_ERROR     = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_CRC_BAD   = 3'd4,
    KIND_MALFORMED = 3'd5
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t        kind;
    logic [7:0]         ftype;
    logic [7:0]         fsize;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               lim_x;
    logic               lim_y;
    logic               lim_z;
  } frame_result_t;

  // Type codes that select the frame classification.
  typedef struct packed {
    logic [7:0] status_code;
    logic [7:0] ack_code;
    logic [7:0] error_code;
  } type_codes_t;

  // One byte through the CRC, eight shift steps unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/crc_frm_parse.sv]
// ----------------------------------------------------------------------------
// CRC frame parser
// Holds the per-frame state, runs the CRC, captures the status payload and
// classifies a frame on its last byte.
// ----------------------------------------------------------------------------
module crc_frm_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,        // consume the presented byte
  input  logic [7:0]                 rx_byte,
  input  crc_frm_pkg::type_codes_t   codes,
  output logic                       emit,      // presented byte ends a frame
  output crc_frm_pkg::frame_result_t result
);

  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  prev_r;
  logic [31:0] pos_r [crc_frm_pkg::NUM_AXES];
  logic [2:0]  flags_r;

  logic [7:0]  eff_len;
  logic [7:0]  eff_type;
  logic        short_len;
  logic        crc_upd;
  logic        last_byte;
  logic [15:0] got_crc;

  // Length and type as seen by this byte.
  assign eff_len   = (idx_r == 8'd0) ? rx_byte : len_r;
  assign eff_type  = (idx_r == 8'd1) ? rx_byte : type_r;
  assign short_len = (idx_r == 8'd0) && (rx_byte < crc_frm_pkg::MIN_FRAME);
  assign crc_upd   = ({1'b0, idx_r} + 9'd2) < {1'b0, eff_len};
  assign last_byte = ({1'b0, idx_r} + 9'd1) >= {1'b0, eff_len};
  assign emit      = short_len || last_byte;

  // The sender's CRC arrives low byte first.
  assign got_crc = {rx_byte, prev_r};

  // Next frame state.
  always_comb begin
    len_nxt  = eff_len;
    type_nxt = eff_type;
    if (emit) begin
      idx_nxt = 8'd0;
      crc_nxt = crc_frm_pkg::CRC_INIT;
    end else begin
      idx_nxt = idx_r + 8'd1;
      crc_nxt = crc_upd ? crc_frm_pkg::crc16_byte(crc_r, rx_byte) : crc_r;
    end
  end

  // Result classification.
  always_comb begin
    result       = '0;
    result.ftype = eff_type;
    result.fsize = eff_len;
    if (short_len) begin
      result.kind  = crc_frm_pkg::KIND_MALFORMED;
      result.ftype = 8'd0;
    end else if (got_crc != crc_r) begin
      result.kind = crc_frm_pkg::KIND_CRC_BAD;
    end else if (eff_type == codes.status_code) begin
      if (eff_len < crc_frm_pkg::MIN_STATUS) begin
        result.kind = crc_frm_pkg::KIND_MALFORMED;
      end else begin
        result.kind  = crc_frm_pkg::KIND_STATUS;
        result.pos_x = pos_r[0];
        result.pos_y = pos_r[1];
        result.pos_z = pos_r[2];
        result.lim_x = flags_r[0];
        result.lim_y = flags_r[1];
        result.lim_z = flags_r[2];
      end
    end else if (eff_type == codes.ack_code) begin
      result.kind = crc_frm_pkg::KIND_ACK;
    end else if (eff_type == codes.error_code) begin
      result.kind = crc_frm_pkg::KIND_ERROR;
    end else begin
      result.kind = crc_frm_pkg::KIND_UNKNOWN;
    end
  end

  // Frame control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 8'd0;
      len_r   <= 8'd0;
      type_r  <= 8'd0;
      crc_r   <= crc_frm_pkg::CRC_INIT;
      flags_r <= 3'd0;
    end else if (go) begin
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      crc_r  <= crc_nxt;
      for (int k = 0; k < crc_frm_pkg::NUM_AXES; k++) begin
        if (idx_r == 8'(crc_frm_pkg::FLAG_FIRST + k)) begin
          flags_r[k] <= (rx_byte == 8'd1);
        end
      end
    end
  end

  // Payload capture: previous byte and the little-endian position words.
  always_ff @(posedge clk) begin
    if (go) begin
      prev_r <= rx_byte;
      for (int w = 0; w < crc_frm_pkg::NUM_AXES; w++) begin
        for (int k = 0; k < 4; k++) begin
          if (idx_r == 8'(crc_frm_pkg::POS_FIRST + 4 * w + k)) begin
            pos_r[w][8*k +: 8] <= rx_byte;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_restart_idx: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit |=> idx_r == 8'd0)
    else $error("byte index did not restart after a frame result");

  a_restart_crc: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit |=> crc_r == crc_frm_pkg::CRC_INIT)
    else $error("CRC did not restart after a frame result");

  a_status_len: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit && result.kind == crc_frm_pkg::KIND_STATUS
      |-> result.fsize >= crc_frm_pkg::MIN_STATUS)
    else $error("status result issued for a short frame");
`endif

endmodule

[hdl/crc_frm_outreg.sv]
// ----------------------------------------------------------------------------
// CRC frame output register
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module crc_frm_outreg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  crc_frm_pkg::frame_result_t load_data,
  input  logic                       take,
  output logic                       valid,
  output logic                       free,      // can load in this cycle
  output crc_frm_pkg::frame_result_t data
);

  logic                       vld_r, vld_nxt;
  crc_frm_pkg::frame_result_t data_r;

  assign free  = !vld_r || take;
  assign valid = vld_r;
  assign data  = data_r;

  // Valid flag: set on load, cleared when the beat is taken.
  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

[hdl/crc_checked_frame_receiver.sv]
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Top level: input byte register, type code registers, frame parser and
// result register.
// ----------------------------------------------------------------------------
// The receiver takes one byte per beat, one byte per clock cycle while the
// result register can take each frame result; the parser's CRC byte update is
// combinational. A byte is held in the input register until the parser takes
// it; a frame result is loaded into the output register when the parser takes
// its last byte (or a length byte below four). While a result waits on the
// output, the block still takes bytes that do not end a frame, and one more
// byte parks in the input register. Type codes are written on the configuration
// port, which is always ready; write them only while no frame is in progress.
module crc_checked_frame_receiver (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input byte stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // [7:0] rx_byte
  // Frame results.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] frame_type, [15:8] frame_size, [47:16] position_x,
  // [79:48] position_y, [111:80] position_z, [112] limit_x,
  // [113] limit_y, [114] limit_z, [119:115] zero
  output logic [crc_frm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [2:0]                            out_tuser,  // [2:0] frame_kind
  // Configuration writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crc_frm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                            cfg_data
);

  logic                       in_vld_r, in_vld_nxt;
  logic [7:0]                 in_byte_r;
  logic                       go;
  logic                       emit;
  logic                       out_free;
  crc_frm_pkg::type_codes_t   codes_r;
  crc_frm_pkg::frame_result_t result;
  crc_frm_pkg::frame_result_t out_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.status_code <= 8'd1;
      codes_r.ack_code    <= 8'd2;
      codes_r.error_code  <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crc_frm_pkg::CFG_STATUS_TYPE: codes_r.status_code <= cfg_data;
        crc_frm_pkg::CFG_ACK_TYPE:    codes_r.ack_code    <= cfg_data;
        crc_frm_pkg::CFG_ERROR_TYPE:  codes_r.error_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The parser consumes the held byte unless it ends a frame and the
  // result register is still occupied.
  assign go        = in_vld_r && (!emit || out_free);
  assign in_tready = !in_vld_r || go;

  always_comb begin
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  crc_frm_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rx_byte (in_byte_r),
    .codes   (codes_r),
    .emit    (emit),
    .result  (result)
  );

  crc_frm_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && emit),
    .load_data (result),
    .take      (out_tready),
    .valid     (out_tvalid),
    .free      (out_free),
    .data      (out_res)
  );

  // Pack the result beat.
  assign out_tuser = out_res.kind;
  assign out_tdata = {5'd0, out_res.lim_z, out_res.lim_y, out_res.lim_x,
                      out_res.pos_z, out_res.pos_y, out_res.pos_x,
                      out_res.fsize, out_res.ftype};

endmodule
